FILE: design/lz78_pkg.sv
// Shared constants and types of the LZ78 encoder.
`timescale 1ns / 1ps

package lz78_pkg;

    // Dictionary geometry: the code space is split across a row of cells
    localparam int DICT_ENTRIES = 4096;
    localparam int CODE_W       = 12;
    localparam int LIMIT_W      = 13;
    localparam int BYTE_W       = 8;
    localparam int KEY_W        = CODE_W + BYTE_W;
    localparam int CELL_BITS    = 6;
    localparam int NUM_CELLS    = 1 << CELL_BITS;
    localparam int ADDR_BITS    = CODE_W - CELL_BITS;
    localparam int CELL_DEPTH   = 1 << ADDR_BITS;

    // Cycles spent after the scan while the match code ripples down the row
    localparam int DRAIN_CYCLES = NUM_CELLS + 2;
    localparam int CNT_W        = 7;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                 start;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
        logic [KEY_W-1:0]     key;
        logic [LIMIT_W-1:0]   next_free;
        logic                 wr_en;
        logic [CODE_W-1:0]    wr_code;
        logic [KEY_W-1:0]     wr_key;
    } cell_ctl_t;

endpackage

FILE: design/lz78_cell.sv
// One dictionary cell: a slice of the code space, its compare and a link of the match chain.
`timescale 1ns / 1ps

module lz78_cell (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [lz78_pkg::CELL_BITS-1:0]   cell_id,
    input  lz78_pkg::cell_ctl_t              ctl,
    input  logic [lz78_pkg::CODE_W-1:0]      chain_in,
    output logic [lz78_pkg::CODE_W-1:0]      chain_out
);
    import lz78_pkg::*;

    logic [KEY_W-1:0]     mem [CELL_DEPTH];
    logic [KEY_W-1:0]     rd_data_reg;
    logic [ADDR_BITS-1:0] rd_addr_reg;
    logic                 rd_valid_reg;
    logic                 hit_reg;
    logic [CODE_W-1:0]    hit_code_reg;
    logic [CODE_W-1:0]    chain_reg;
    logic [CODE_W-1:0]    code;
    logic                 match;
    logic                 wr_here;

    // Codes whose low bits name this cell live here
    assign wr_here = ctl.wr_en && (ctl.wr_code[CELL_BITS-1:0] == cell_id);

    // Write one entry, read one entry per cycle
    always_ff @(posedge aclk) begin
        if (wr_here) begin
            mem[ctl.wr_code[CODE_W-1:CELL_BITS]] <= ctl.wr_key;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[ctl.rd_addr];
        end
        rd_addr_reg <= ctl.rd_addr;
    end

    // Only codes 1 .. next_free-1 are live
    assign code  = {rd_addr_reg, cell_id};
    assign match = rd_valid_reg && (code != '0)
                   && ({1'b0, code} < ctl.next_free) && (rd_data_reg == ctl.key);

    // Hold the local hit; merge it into the chain from the left neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
            chain_reg    <= '0;
        end else begin
            rd_valid_reg <= ctl.rd_en;
            if (ctl.start) begin
                hit_reg   <= 1'b0;
                chain_reg <= '0;
            end else begin
                if (match) begin
                    hit_reg <= 1'b1;
                end
                chain_reg <= chain_in | (hit_reg ? hit_code_reg : '0);
            end
        end
    end

    // Capture the matching code
    always_ff @(posedge aclk) begin
        if (match) begin
            hit_code_reg <= code;
        end
    end

    assign chain_out = chain_reg;

endmodule

FILE: design/lz78_encoder.sv
// Top level of the LZ78 encoder: stream ports, sequencer and the row of dictionary cells.
//
// Usage:
//   s_axis carries one raw byte per item, tlast on the final byte of a stream.
//   m_axis carries (code_index, code_byte) pairs, tlast on the final pair.
//   cfg_valid/cfg_data write dict_limit; write it only while the block is idle.
// Lookup:
//   Each byte is looked up against the dictionary by a row of 64 cells, each
//   holding 64 entries in its own memory. All cells scan their memory in
//   parallel (one read port per cell), then the match code ripples down the
//   cell chain, then the resolve state settles the step; it waits there while
//   a result must go out and the output register is still full.
//   A new byte is accepted only after the previous step has resolved.
// Reset:
//   aresetn (synchronous, active low) returns to the root, empties the
//   dictionary (next free code 1) and sets dict_limit to 4096.
// Backpressure:
//   A result waits in the output register; the next byte is accepted while it
//   waits. A later result holds the sequencer until the register frees.
`timescale 1ns / 1ps

module lz78_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // in_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [11:0] code_index, [19:12] code_byte, zero pad
    output logic        m_axis_tlast,   // out_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [lz78_pkg::LIMIT_W-1:0] cfg_data   // dict_limit
);
    import lz78_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_SCAN    = 4'b0010,
        ST_DRAIN   = 4'b0100,
        ST_RESOLVE = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CODE_W-1:0]   node_reg, node_next;
    logic [LIMIT_W-1:0]  next_free_reg, next_free_next;
    logic [LIMIT_W-1:0]  dict_limit_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic                last_reg;
    logic                m_valid_reg;
    logic [CODE_W-1:0]   m_index_reg;
    logic [BYTE_W-1:0]   m_byte_reg;
    logic                m_last_reg;

    logic                accept;
    logic [CODE_W-1:0]   child;
    logic                hit;
    logic                emit;
    logic                out_free;
    logic                fire;
    logic [LIMIT_W-1:0]  limit;
    logic                grow;
    cell_ctl_t           ctl;
    logic [CODE_W-1:0]   chain [NUM_CELLS+1];

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    // Resolve the lookup once the chain has settled
    assign child    = chain[NUM_CELLS];
    assign hit      = (child != '0);
    assign emit     = !hit || last_reg;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign fire     = (state_reg == ST_RESOLVE) && (!emit || out_free);
    assign limit    = (dict_limit_reg > LIMIT_W'(DICT_ENTRIES)) ? LIMIT_W'(DICT_ENTRIES)
                                                                : dict_limit_reg;
    assign grow     = (next_free_reg < limit);

    // Broadcast control to the cells
    always_comb begin
        ctl.start     = accept;
        ctl.rd_en     = (state_reg == ST_SCAN);
        ctl.rd_addr   = cnt_reg[ADDR_BITS-1:0];
        ctl.key       = {node_reg, byte_reg};
        ctl.next_free = next_free_reg;
        ctl.wr_en     = fire && !hit && grow;
        ctl.wr_code   = next_free_reg[CODE_W-1:0];
        ctl.wr_key    = {node_reg, byte_reg};
    end

    // Row of cells; the chain enters empty at the left end
    assign chain[0] = '0;
    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        lz78_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_id   (CELL_BITS'(i)),
            .ctl       (ctl),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // Sequence scan, drain and resolve
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CNT_W'(CELL_DEPTH - 1)) begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (cnt_reg == CNT_W'(DRAIN_CYCLES - 1)) begin
                    state_next = ST_RESOLVE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_RESOLVE: begin
                if (fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Walk state: advance on a hit, return to root on a miss (adding an entry if room), clear at stream end
    always_comb begin
        node_next      = node_reg;
        next_free_next = next_free_reg;
        if (fire) begin
            if (last_reg) begin
                node_next      = '0;
                next_free_next = LIMIT_W'(1);
            end else if (hit) begin
                node_next = child;
            end else begin
                node_next = '0;
                if (grow) begin
                    next_free_next = next_free_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            node_reg       <= '0;
            next_free_reg  <= LIMIT_W'(1);
            dict_limit_reg <= LIMIT_W'(DICT_ENTRIES);
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            node_reg      <= node_next;
            next_free_reg <= next_free_next;
            if (cfg_valid && cfg_ready) begin
                dict_limit_reg <= cfg_data;
            end
            if (fire && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item and the result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
        if (fire && emit) begin
            m_index_reg <= hit ? child : node_reg;
            m_byte_reg  <= hit ? '0 : byte_reg;
            m_last_reg  <= last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, m_byte_reg, m_index_reg};
    assign m_axis_tlast  = m_last_reg;

    // The free code never runs past the dictionary
    assert property (@(posedge aclk) disable iff (!aresetn)
        (next_free_reg >= LIMIT_W'(1)) && (next_free_reg <= LIMIT_W'(DICT_ENTRIES)))
        else $error("next free code out of range");

    // The open match is always the root or a live code
    assert property (@(posedge aclk) disable iff (!aresetn)
        (node_reg == '0) || ({1'b0, node_reg} < next_free_reg))
        else $error("current node is not a live code");

    // A found child is a live code
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESOLVE) |-> (!hit || ({1'b0, child} < next_free_reg)))
        else $error("lookup returned a dead code");

    // An accepted item starts a scan
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_SCAN) && (cnt_reg == '0))
        else $error("accepted item did not start a scan");

    // A pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |-> !(fire && emit))
        else $error("result register overwritten");

endmodule

FILE: tb/tb_lz78_encoder.sv
// Self-checking testbench of the LZ78 encoder: directed table, random streams, scoreboard.
`timescale 1ns / 1ps

module tb_lz78_encoder;

    import lz78_pkg::*;

    localparam int SETTLE_CYCLES = 4 * DRAIN_CYCLES;
    localparam int HOLD_CYCLES   = 1500;
    localparam int NUM_PHASES    = 9;

    typedef enum logic {ROW_BYTE, ROW_LIMIT} row_kind_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_index;
        logic [BYTE_W-1:0] code_byte;
        logic              code_last;
    } pair_t;

    // Per accepted byte: optional hand-written expectation
    typedef struct {
        logic  typed;
        logic  t_has;
        pair_t t_pair;
    } note_t;

    typedef struct {
        row_kind_t          kind;
        logic [LIMIT_W-1:0] value;
        logic               last;
        note_t              note;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;   // [7:0] in_byte
    logic               s_axis_tlast = 1'b0; // in_last
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;        // [11:0] code_index, [19:12] code_byte, zero pad
    logic               m_axis_tlast;        // out_last
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;       // dict_limit

    lz78_encoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // Trie model state
    logic [KEY_W-1:0]   dict_key [DICT_ENTRIES];
    logic [CODE_W-1:0]  walk_node;
    int                 free_code;
    logic [LIMIT_W-1:0] limit_reg;

    pair_t expected_pairs [$];
    note_t byte_notes [$];
    row_t  directed_rows [$];

    int fail_cnt   = 0;
    int send_idle  = 0;
    int recv_stall = 0;
    int hold_ask   = 0;

    // Random phases: limit, sender idle %, receiver stall %, items, long hold-off
    int phase_limit [NUM_PHASES] = '{4096, 3, 8191, 1, 4096, 64, 0, 17, 4096};
    int phase_send  [NUM_PHASES] = '{0, 73, 0, 0, 11, 0, 0, 11, 73};
    int phase_recv  [NUM_PHASES] = '{0, 0, 73, 0, 11, 73, 73, 11, 0};
    int phase_items [NUM_PHASES] = '{100, 90, 100, 60, 120, 100, 60, 90, 80};
    int phase_hold  [NUM_PHASES] = '{0, 0, 0, 1, 0, 0, 0, 0, 0};

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Walk the trie for one byte; return the pair it emits, if any
    function automatic void encode_step(input logic [7:0] in_b, input logic in_l,
                                        output logic has, output pair_t p);
        logic [CODE_W-1:0] child;
        logic [KEY_W-1:0]  key;
        int                lim;
        int                c;
        child = '0;
        key   = {walk_node, in_b};
        has   = 1'b0;
        p     = '0;
        for (c = 1; c < free_code && c < DICT_ENTRIES; c++) begin
            if (child == '0 && dict_key[c] == key) begin
                child = c[CODE_W-1:0];
            end
        end
        if (child != '0) begin
            walk_node = child;
            if (in_l) begin
                has          = 1'b1;
                p.code_index = child;
                p.code_byte  = 8'h00;
                p.code_last  = 1'b1;
            end
        end else begin
            lim          = (int'(limit_reg) > DICT_ENTRIES) ? DICT_ENTRIES : int'(limit_reg);
            has          = 1'b1;
            p.code_index = walk_node;
            p.code_byte  = in_b;
            p.code_last  = in_l;
            if (free_code < lim) begin
                dict_key[free_code] = key;
                free_code++;
            end
            walk_node = '0;
        end
        if (in_l) begin
            walk_node = '0;
            free_code = 1;
        end
    endfunction

    // Scoreboard: check results, predict on accepted bytes, track the register
    always @(posedge aclk) begin : scoreboard
        pair_t want;
        pair_t got;
        pair_t pred;
        logic  pred_has;
        note_t n;
        if (!aresetn) begin
            walk_node = '0;
            free_code = 1;
            limit_reg = LIMIT_W'(4096);
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.code_index = m_axis_tdata[11:0];
                got.code_byte  = m_axis_tdata[19:12];
                got.code_last  = m_axis_tlast;
                if (expected_pairs.size() == 0) begin
                    $error("result with no expectation waiting: code_index %0d code_byte %0d",
                           got.code_index, got.code_byte);
                    fail_cnt++;
                end else begin
                    want = expected_pairs.pop_front();
                    if (got.code_index != want.code_index) begin
                        $error("code_index: expected %0d, actual %0d",
                               want.code_index, got.code_index);
                        fail_cnt++;
                    end
                    if (got.code_byte != want.code_byte) begin
                        $error("code_byte: expected %0d, actual %0d",
                               want.code_byte, got.code_byte);
                        fail_cnt++;
                    end
                    if (got.code_last != want.code_last) begin
                        $error("out_last: expected %0d, actual %0d",
                               want.code_last, got.code_last);
                        fail_cnt++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                n = byte_notes.pop_front();
                encode_step(s_axis_tdata, s_axis_tlast, pred_has, pred);
                if (n.typed) begin
                    pred_has = n.t_has;
                    pred     = n.t_pair;
                end
                if (pred_has) begin
                    expected_pairs.push_back(pred);
                end
            end
            if (cfg_valid && cfg_ready) begin
                limit_reg = cfg_data;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when asked
    always @(posedge aclk) begin : receiver
        int hold_left;
        int hold_seen;
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // Offer one byte after a random gap; return at the edge it is accepted
    task automatic offer_byte(input logic [7:0] b, input logic l, input note_t n);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        byte_notes.push_back(n);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= l;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until the block has nothing left in flight
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_pairs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_byte(input logic [7:0] b, input logic l);
        row_t r;
        r.kind  = ROW_BYTE;
        r.value = LIMIT_W'(b);
        r.last  = l;
        r.note  = '{typed: 1'b0, t_has: 1'b0, t_pair: '0};
        directed_rows.push_back(r);
    endtask

    task automatic add_pair(input logic [7:0] b, input logic l, input logic [CODE_W-1:0] idx,
                            input logic [7:0] cb, input logic cl);
        row_t r;
        r.kind  = ROW_BYTE;
        r.value = LIMIT_W'(b);
        r.last  = l;
        r.note  = '{typed: 1'b1, t_has: 1'b1, t_pair: {idx, cb, cl}};
        directed_rows.push_back(r);
    endtask

    task automatic add_limit(input logic [LIMIT_W-1:0] v);
        row_t r;
        r.kind  = ROW_LIMIT;
        r.value = v;
        r.last  = 1'b0;
        r.note  = '{typed: 1'b0, t_has: 1'b0, t_pair: '0};
        directed_rows.push_back(r);
    endtask

    initial begin : stimulus
        note_t       rnd_note;
        int          stream_left;
        int          sym_base;
        int          sym_span;
        logic        noisy;
        logic [7:0]  b;
        rnd_note = '{typed: 1'b0, t_has: 1'b0, t_pair: '0};
        stream_left = 0;
        sym_base = 0;
        sym_span = 2;
        noisy = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Fresh dictionary at the reset limit: extremes, hits, an ending on a miss
        add_pair(8'h00, 1'b0, 12'd0, 8'h00, 1'b0);
        add_pair(8'hFF, 1'b0, 12'd0, 8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b1);
        // Miss on the final byte, then a hit on the final byte
        add_pair(8'hA5, 1'b1, 12'd0, 8'hA5, 1'b1);
        add_pair(8'h5A, 1'b0, 12'd0, 8'h5A, 1'b0);
        add_pair(8'h5A, 1'b1, 12'd1, 8'h00, 1'b1);
        // Limits of one and zero: no growth, every byte emitted from the root
        add_limit(LIMIT_W'(1));
        add_pair(8'h37, 1'b0, 12'd0, 8'h37, 1'b0);
        add_pair(8'h37, 1'b0, 12'd0, 8'h37, 1'b0);
        add_pair(8'h80, 1'b1, 12'd0, 8'h80, 1'b1);
        add_limit(LIMIT_W'(0));
        add_pair(8'h01, 1'b0, 12'd0, 8'h01, 1'b0);
        add_pair(8'h01, 1'b1, 12'd0, 8'h01, 1'b1);
        // Limit of two: a single entry, then the dictionary is full
        add_limit(LIMIT_W'(2));
        add_pair(8'h10, 1'b0, 12'd0, 8'h10, 1'b0);
        add_pair(8'h20, 1'b0, 12'd0, 8'h20, 1'b0);
        add_byte(8'h10, 1'b0);
        add_byte(8'h20, 1'b0);
        add_byte(8'h10, 1'b0);
        add_byte(8'h10, 1'b1);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_LIMIT) begin
                write_limit(directed_rows[i].value);
            end else begin
                offer_byte(directed_rows[i].value[7:0], directed_rows[i].last,
                           directed_rows[i].note);
            end
        end

        // Random streams; a stream may run across a limit change
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_limit(LIMIT_W'(phase_limit[ph]));
            send_idle  = phase_send[ph];
            recv_stall = phase_recv[ph];
            if (phase_hold[ph] != 0) begin
                hold_ask++;
            end
            for (int k = 0; k < phase_items[ph]; k++) begin
                if (stream_left == 0) begin
                    stream_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
                    noisy       = ($urandom_range(4) == 0);
                    sym_base    = $urandom_range(255);
                    sym_span    = $urandom_range(4, 2);
                end
                if (noisy) begin
                    b = 8'($urandom_range(255));
                end else begin
                    b = 8'(sym_base + $urandom_range(sym_span - 1));
                end
                offer_byte(b, stream_left == 1, rnd_note);
                stream_left--;
            end
        end

        settle_block();
        if (fail_cnt == 0 && expected_pairs.size() == 0) begin
            $display("tb_lz78_encoder passed");
        end else begin
            $display("tb_lz78_encoder failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("tb_lz78_encoder failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/lz78_pkg.sv
design/lz78_cell.sv
design/lz78_encoder.sv
tb/tb_lz78_encoder.sv
